>>> hw/rtl/swmd_pkg.sv
// shared constants and helpers for the sliding window max demand block
`default_nettype none
package swmd_pkg;

  localparam int SampleW = 24;
  localparam int StampW  = 32;

  typedef enum logic [1:0] {
    FUNC_SAMPLE    = 2'd0,
    FUNC_CLR_DAY   = 2'd1,
    FUNC_CLR_MONTH = 2'd2,
    FUNC_NONE      = 2'd3
  } func_e;

  // two bcd digits of a value below 100
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] units;
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(10 * k)) tens = 4'(k);
    end
    units = v - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/swmd_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module swmd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AddrW-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]        wdata_i,
  input  wire logic                    re_i,
  input  wire logic [AddrW-1:0]        raddr_i,
  output logic      [WIDTH-1:0]        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> hw/rtl/sliding_window_max_demand_top.sv
// sliding window maximum demand per point and channel, with day and month peaks
// path: a power sample passes the accumulate, drop, divide and update states to reach the output
// register, the divide state running the SumW-step restoring divider; other items go to update
// throughput: one item at a time, input ready only while the sequencer is idle, so a new item
// is taken only after the last one leaves the update state, which waits out any output stall
// reset: rst_ni clears all per-entry state at once; ring slot data is only used once written
`default_nettype none
module sliding_window_max_demand_top #(
  parameter int POINTS     = 8,
  parameter int RING_SLOTS = 16,
  parameter int WINDOW_LEN = 15,
  parameter int MIN_FILL   = 10,
  parameter int CHANNELS   = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [2:0]  point_index_i,
  input  wire logic [1:0]  channel_i,
  input  wire logic signed [23:0] sample_i,
  input  wire logic [3:0]  month_i,
  input  wire logic [4:0]  day_of_month_i,
  input  wire logic [4:0]  hour_i,
  input  wire logic [5:0]  minute_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [23:0]      demand_o,
  output logic             demand_valid_o,
  output logic             new_day_max_o,
  output logic             new_month_max_o,
  output logic [23:0]      day_max_o,
  output logic [31:0]      day_max_stamp_o,
  output logic [23:0]      month_max_o,
  output logic [31:0]      month_max_stamp_o
);
  import swmd_pkg::*;

  // sizes derived from the parameters
  localparam int Entries = POINTS * CHANNELS;
  localparam int EntW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int WinEff  = (WINDOW_LEN < RING_SLOTS) ? WINDOW_LEN : RING_SLOTS;
  localparam int CntW    = $clog2(WinEff + 1);
  localparam int SumW    = SampleW + CntW;
  localparam int SlotW   = $clog2(RING_SLOTS);
  localparam int RamD    = Entries * RING_SLOTS;
  localparam int RamAw   = (RamD > 1) ? $clog2(RamD) : 1;
  localparam int DivCW   = $clog2(SumW + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_DROP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0] state_q, state_d;

  // per-entry state in flops, cleared by reset
  logic signed [SumW-1:0] sum_q  [Entries];
  logic [CntW-1:0]        cnt_q  [Entries];
  logic [SlotW-1:0]       head_q [Entries];
  logic [SlotW-1:0]       tail_q [Entries];
  logic [SampleW-1:0]     dpk_q  [Entries];
  logic [StampW-1:0]      dpt_q  [Entries];
  logic [SampleW-1:0]     mpk_q  [Entries];
  logic [StampW-1:0]      mpt_q  [Entries];

  // latched item
  func_e                  func_q;
  logic                   oor_q;
  logic [EntW-1:0]        ent_q;
  logic signed [SampleW-1:0] smp_q;
  logic [StampW-1:0]      stamp_q;
  logic                   drop_q;
  logic                   valid_q;

  // shared divider registers: num_q shifts out the dividend and in the quotient
  logic [SumW-1:0]        num_q;
  logic [CntW-1:0]        den_q;
  logic [CntW-1:0]        rem_q;
  logic [DivCW-1:0]       dcnt_q;

  // output register
  logic                   ovld_q;
  logic [23:0]            odem_q, odmx_q, ommx_q;
  logic                   odv_q, ond_q, onm_q;
  logic [31:0]            odst_q, omst_q;

  logic [11:0]            ent_wide;
  logic [EntW-1:0]        ent_in;
  logic                   oor_in;
  logic [StampW-1:0]      stamp_in;
  logic                   in_xfer;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign ent_wide   = 12'(point_index_i) * 12'(CHANNELS) + 12'(channel_i);
  assign ent_in     = ent_wide[EntW-1:0];
  assign oor_in     = (32'(point_index_i) >= 32'(POINTS)) ||
                      (32'(channel_i) >= 32'(CHANNELS));
  assign stamp_in   = {to_bcd(7'(month_i)), to_bcd(7'(day_of_month_i)),
                       to_bcd(7'(hour_i)), to_bcd(7'(minute_i))};

  // window arithmetic for the accumulate step
  logic signed [SumW-1:0] sum_new;
  logic [CntW-1:0]        cnt_new;
  logic [SumW-1:0]        abs_new;
  assign sum_new = sum_q[ent_q] + SumW'(smp_q);
  assign cnt_new = cnt_q[ent_q] + CntW'(1);
  assign abs_new = sum_new[SumW-1] ? SumW'(-sum_new) : SumW'(sum_new);

  // ring memory: write at tail during accumulate, read head in the same cycle
  logic [SampleW-1:0] ring_rd;
  logic               ring_we, ring_re;
  logic [RamAw-1:0]   ring_wa, ring_ra;
  assign ring_we = (state_q == S_ACC);
  assign ring_re = (state_q == S_ACC);
  assign ring_wa = RamAw'(32'(ent_q) * 32'(RING_SLOTS) + 32'(tail_q[ent_q]));
  assign ring_ra = RamAw'(32'(ent_q) * 32'(RING_SLOTS) + 32'(head_q[ent_q]));

  swmd_ram #(
    .WIDTH (SampleW),
    .DEPTH (RamD)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_wa),
    .wdata_i (smp_q),
    .re_i    (ring_re),
    .raddr_i (ring_ra),
    .rdata_o (ring_rd)
  );

  // one restoring divide step per cycle
  logic [CntW:0] rem_sh;
  logic          div_ge;
  assign rem_sh = {rem_q, num_q[SumW-1]};
  assign div_ge = rem_sh >= (CntW+1)'(den_q);

  // peak update for the result
  logic [23:0] dem;
  logic        nd, nm;
  logic [23:0] dmx_n, mmx_n;
  logic [31:0] dst_n, mst_n;
  logic        out_free;
  assign dem      = valid_q ? num_q[23:0] : 24'd0;
  assign nd       = valid_q && (dem > dpk_q[ent_q]);
  assign nm       = valid_q && (dem > mpk_q[ent_q]);
  assign out_free = !ovld_q || out_ready_i;

  always_comb begin
    dmx_n = dpk_q[ent_q];
    dst_n = dpt_q[ent_q];
    mmx_n = mpk_q[ent_q];
    mst_n = mpt_q[ent_q];
    if (func_q == FUNC_CLR_DAY) begin
      dmx_n = '0;
      dst_n = '0;
    end else if (nd) begin
      dmx_n = dem;
      dst_n = stamp_q;
    end
    if (func_q == FUNC_CLR_MONTH) begin
      mmx_n = '0;
      mst_n = '0;
    end else if (nm) begin
      mmx_n = dem;
      mst_n = stamp_q;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_xfer) begin
        state_d = (func_i == FUNC_SAMPLE && !oor_in) ? S_ACC : S_UPD;
      end
      S_ACC:  state_d = S_DROP;
      S_DROP: state_d = S_DIV;
      S_DIV:  if (dcnt_q == DivCW'(1)) state_d = S_UPD;
      S_UPD:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
      for (int i = 0; i < Entries; i++) begin
        sum_q[i]  <= '0;
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
        tail_q[i] <= '0;
        dpk_q[i]  <= '0;
        dpt_q[i]  <= '0;
        mpk_q[i]  <= '0;
        mpt_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      // a new result may replace the one leaving in the same cycle
      if (state_q == S_UPD && out_free) ovld_q <= 1'b1;
      else if (out_valid_o && out_ready_i) ovld_q <= 1'b0;
      if (state_q == S_ACC) begin
        sum_q[ent_q]  <= sum_new;
        cnt_q[ent_q]  <= cnt_new;
        tail_q[ent_q] <= (tail_q[ent_q] == SlotW'(RING_SLOTS - 1)) ? '0
                         : tail_q[ent_q] + SlotW'(1);
      end
      // drop the oldest sample once the window is full
      if (state_q == S_DROP && drop_q) begin
        sum_q[ent_q]  <= sum_q[ent_q] - SumW'($signed(ring_rd));
        cnt_q[ent_q]  <= cnt_q[ent_q] - CntW'(1);
        head_q[ent_q] <= (head_q[ent_q] == SlotW'(RING_SLOTS - 1)) ? '0
                         : head_q[ent_q] + SlotW'(1);
      end
      if (state_q == S_UPD && out_free) begin
        if (!oor_q) begin
          dpk_q[ent_q] <= dmx_n;
          dpt_q[ent_q] <= dst_n;
          mpk_q[ent_q] <= mmx_n;
          mpt_q[ent_q] <= mst_n;
        end
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q  <= func_e'(func_i);
      oor_q   <= oor_in;
      ent_q   <= ent_in;
      smp_q   <= sample_i;
      stamp_q <= stamp_in;
      valid_q <= 1'b0;
    end
    if (state_q == S_ACC) begin
      drop_q  <= 32'(cnt_new) >= 32'(WinEff);
      valid_q <= 32'(cnt_new) >= 32'(MIN_FILL);
      num_q   <= abs_new;
      den_q   <= cnt_new;
      rem_q   <= '0;
      dcnt_q  <= DivCW'(SumW);
    end
    if (state_q == S_DIV) begin
      rem_q  <= div_ge ? CntW'(rem_sh - (CntW+1)'(den_q)) : rem_sh[CntW-1:0];
      num_q  <= {num_q[SumW-2:0], div_ge};
      dcnt_q <= dcnt_q - DivCW'(1);
    end
    if (state_q == S_UPD && out_free) begin
      odem_q <= oor_q ? '0 : dem;
      odv_q  <= !oor_q && valid_q;
      ond_q  <= !oor_q && nd;
      onm_q  <= !oor_q && nm;
      odmx_q <= oor_q ? '0 : dmx_n;
      odst_q <= oor_q ? '0 : dst_n;
      ommx_q <= oor_q ? '0 : mmx_n;
      omst_q <= oor_q ? '0 : mst_n;
    end
  end

  assign out_valid_o       = ovld_q;
  assign demand_o          = odem_q;
  assign demand_valid_o    = odv_q;
  assign new_day_max_o     = ond_q;
  assign new_month_max_o   = onm_q;
  assign day_max_o         = odmx_q;
  assign day_max_stamp_o   = odst_q;
  assign month_max_o       = ommx_q;
  assign month_max_stamp_o = omst_q;

`ifndef SYNTHESIS
  a_nd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_day_max_o |-> demand_valid_o && day_max_o == demand_o)
    else $error("new day max without matching demand");
  a_nm_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_month_max_o |-> demand_valid_o && month_max_o == demand_o)
    else $error("new month max without matching demand");
  a_dem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !demand_valid_o |-> demand_o == 24'd0)
    else $error("demand nonzero while not valid");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && dcnt_q == DivCW'(1) |=> state_q == S_UPD)
    else $error("divider did not hand over to update");
`endif
endmodule
`default_nettype wire

>>> test/tb_sliding_window_max_demand_top.sv
// testbench for the sliding window max demand block: random and directed traffic checked
// against a cycle-free behavioral predictor
`default_nettype none
module tb_sliding_window_max_demand_top;
  import swmd_pkg::*;

  localparam int Points   = 8;
  localparam int Channels = 4;
  localparam int Slots    = 16;
  localparam int WinLen   = 15;   // smaller of window length and ring size
  localparam int MinFill  = 10;
  localparam int Entries  = Points * Channels;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // input channel
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = '0;
  logic [2:0]  point_index_i = '0;
  logic [1:0]  channel_i = '0;
  logic signed [23:0] sample_i = '0;
  logic [3:0]  month_i = 4'd1;
  logic [4:0]  day_of_month_i = 5'd1;
  logic [4:0]  hour_i = '0;
  logic [5:0]  minute_i = '0;
  // result channel
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [23:0] demand_o;
  logic        demand_valid_o;
  logic        new_day_max_o;
  logic        new_month_max_o;
  logic [23:0] day_max_o;
  logic [31:0] day_max_stamp_o;
  logic [23:0] month_max_o;
  logic [31:0] month_max_stamp_o;

  sliding_window_max_demand_top DUT (.*);

  typedef struct packed {
    logic [23:0] demand;
    logic        dvalid;
    logic        new_day;
    logic        new_month;
    logic [23:0] day_max;
    logic [31:0] day_stamp;
    logic [23:0] month_max;
    logic [31:0] month_stamp;
  } demand_rpt_t;

  // predictor copy of the per-entry state
  logic signed [23:0] ring_mem [Entries][Slots];
  longint             win_sum  [Entries];
  int                 win_cnt  [Entries];
  int                 rd_ptr   [Entries];
  int                 wr_ptr   [Entries];
  logic [23:0]        day_pk   [Entries];
  logic [31:0]        day_ts   [Entries];
  logic [23:0]        mon_pk   [Entries];
  logic [31:0]        mon_ts   [Entries];

  demand_rpt_t pending_rpts[$];
  int  n_errors = 0;
  int  n_results = 0;
  int  n_sent = 0;
  bit  hold_off = 1'b0;   // forces the receiver to stall
  bit  no_stall = 1'b0;   // receiver always ready unless hold_off is set

  function automatic logic [7:0] bcd2(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // advance predictor state by one transfer and return the expected result
  function automatic demand_rpt_t predict_demand(input logic [1:0] fn, input int e,
      input logic signed [23:0] s, input logic [31:0] stamp);
    demand_rpt_t r;
    longint avg;
    r = '0;
    if (fn == FUNC_SAMPLE) begin
      ring_mem[e][wr_ptr[e]] = s;
      wr_ptr[e] = (wr_ptr[e] + 1) % Slots;
      win_sum[e] += longint'(s);
      win_cnt[e]++;
      if (win_cnt[e] >= MinFill) begin
        avg = win_sum[e] / win_cnt[e];   // truncates toward zero
        if (avg < 0) avg = -avg;
        r.demand = 24'(avg);
        r.dvalid = 1'b1;
      end
      while (win_cnt[e] >= WinLen) begin
        win_sum[e] -= longint'(ring_mem[e][rd_ptr[e]]);
        rd_ptr[e] = (rd_ptr[e] + 1) % Slots;
        win_cnt[e]--;
      end
      if (r.dvalid) begin
        if (r.demand > day_pk[e]) begin
          day_pk[e] = r.demand; day_ts[e] = stamp; r.new_day = 1'b1;
        end
        if (r.demand > mon_pk[e]) begin
          mon_pk[e] = r.demand; mon_ts[e] = stamp; r.new_month = 1'b1;
        end
      end
    end else if (fn == FUNC_CLR_DAY) begin
      day_pk[e] = '0; day_ts[e] = '0;
    end else if (fn == FUNC_CLR_MONTH) begin
      mon_pk[e] = '0; mon_ts[e] = '0;
    end
    r.day_max = day_pk[e];     r.day_stamp = day_ts[e];
    r.month_max = mon_pk[e];   r.month_stamp = mon_ts[e];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    n_errors++;
    $display("mismatch on %s: got %h expected %h (result %0d)", what, got, want, n_results);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one transfer on the input channel; payload changes on the falling edge
  // the block is never ready in the cycle after a transfer, so the pause before
  // offering the next item costs no throughput
  task automatic send_item(input logic [1:0] fn, input logic [2:0] pt, input logic [1:0] ch,
      input logic signed [23:0] s, input logic [3:0] mo, input logic [4:0] dy,
      input logic [4:0] hr, input logic [5:0] mi, input bit with_gap = 1'b1);
    int g;
    g = with_gap ? gap_len() : 0;
    repeat (g + 1) @(negedge clk_i);
    func_i <= fn; point_index_i <= pt; channel_i <= ch; sample_i <= s;
    month_i <= mo; day_of_month_i <= dy; hour_i <= hr; minute_i <= mi;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rpts.push_back(predict_demand(fn, int'(pt) * Channels + int'(ch), s,
        {bcd2(mo), bcd2(dy), bcd2(hr), bcd2(mi)}));
    n_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // receiver ready pattern: random stalls, plus a long forced hold-off
  always @(negedge clk_i) begin
    int g;
    if (hold_off) out_ready_i <= 1'b0;
    else if (no_stall) out_ready_i <= 1'b1;
    else begin
      g = gap_len();
      out_ready_i <= (g == 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    demand_rpt_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_rpts.size() == 0) begin
        report_mismatch("result with none expected", 32'd1, 32'd0);
      end else begin
        w = pending_rpts.pop_front();
        if (demand_o != w.demand) report_mismatch("demand", demand_o, w.demand);
        if (demand_valid_o != w.dvalid) report_mismatch("demand_valid", demand_valid_o, w.dvalid);
        if (new_day_max_o != w.new_day) report_mismatch("new_day_max", new_day_max_o, w.new_day);
        if (new_month_max_o != w.new_month)
          report_mismatch("new_month_max", new_month_max_o, w.new_month);
        if (day_max_o != w.day_max) report_mismatch("day_max", day_max_o, w.day_max);
        if (day_max_stamp_o != w.day_stamp)
          report_mismatch("day_max_stamp", day_max_stamp_o, w.day_stamp);
        if (month_max_o != w.month_max) report_mismatch("month_max", month_max_o, w.month_max);
        if (month_max_stamp_o != w.month_stamp)
          report_mismatch("month_max_stamp", month_max_stamp_o, w.month_stamp);
      end
    end
  end

  task automatic wait_drained();
    while (pending_rpts.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random(input logic [2:0] pt, input logic [1:0] ch, input int kind);
    logic signed [23:0] s;
    logic [1:0] fn;
    case (kind)
      0: s = 24'($urandom);                                // full range
      1: s = 24'($signed($urandom_range(0, 2000)) - 1000);  // near zero, signs mix
      default: s = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
    endcase
    fn = ($urandom_range(0, 39) == 0) ? 2'($urandom_range(1, 3)) : FUNC_SAMPLE;
    send_item(fn, pt, ch, s, 4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
        5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
  endtask

  // extremes of every field, every function code, sign extremes up to and past the minimum fill
  task automatic test_directed();
    send_item(FUNC_NONE, 3'd0, 2'd0, 24'sd0, 4'd1, 5'd1, 5'd0, 6'd0);
    for (int i = 0; i < 12; i++)
      send_item(FUNC_SAMPLE, 3'd7, 2'd3, 24'sh800000, 4'd12, 5'd31, 5'd23, 6'd59);
    send_item(FUNC_SAMPLE, 3'd7, 2'd3, 24'sh7fffff, 4'd15, 5'd31, 5'd31, 6'd63);
    send_item(FUNC_CLR_DAY, 3'd7, 2'd3, 24'sh7fffff, 4'd1, 5'd1, 5'd0, 6'd0);
    send_item(FUNC_NONE, 3'd7, 2'd3, 24'sd0, 4'd1, 5'd1, 5'd0, 6'd0);
    send_item(FUNC_CLR_MONTH, 3'd7, 2'd3, 24'sd0, 4'd1, 5'd1, 5'd0, 6'd0);
    for (int i = 0; i < 10; i++)
      send_item(FUNC_SAMPLE, 3'd0, 2'd0, 24'sh7fffff, 4'd0, 5'd0, 5'd0, 6'd0);
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_random(3'd2, 2'd1, 0);
    join
    wait_drained();
  endtask

  // mostly focused bursts on a few entries so windows fill, with random gaps
  task automatic test_random(input int n);
    logic [2:0] pt;
    logic [1:0] ch;
    int k;
    while (n > 0) begin
      pt = 3'($urandom); ch = 2'($urandom);
      k = $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) k = 2;
      for (int j = 0; j < $urandom_range(5, 30) && n > 0; j++, n--)
        send_random(pt, ch, k == 2 ? ($urandom_range(0, 3) == 0 ? 2 : 1) : k);
      if ($urandom_range(0, 9) == 0) begin
        no_stall = $urandom_range(0, 1);
        wait_drained();   // sender pause until all results are back
      end
    end
  endtask

  initial begin
    for (int e = 0; e < Entries; e++) begin
      win_sum[e] = 0; win_cnt[e] = 0; rd_ptr[e] = 0; wr_ptr[e] = 0;
      day_pk[e] = '0; day_ts[e] = '0; mon_pk[e] = '0; mon_ts[e] = '0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    wait_drained();
    test_backpressure();
    test_random(2000);
    wait_drained();
    repeat (100) @(negedge clk_i);
    $display("covered %0d transfers in, %0d results out: directed extremes, clears,",
        n_sent, n_results);
    $display("long receiver hold-off and random windowed traffic on all entries");
    if (n_errors == 0 && pending_rpts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/swmd_pkg.sv
hw/rtl/swmd_ram.sv
hw/rtl/sliding_window_max_demand_top.sv
test/tb_sliding_window_max_demand_top.sv
